/* src/lpse_pkg.sv */
// ============================================================================
// lpse_pkg
// Shared types and constants for the LED pixel SPI encoder.
// ============================================================================
package lpse_pkg;

    localparam int CHAN_W          = 8;
    localparam int SPI_BITS_PER_BIT = 5;
    localparam int WORD_W          = CHAN_W * SPI_BITS_PER_BIT;
    localparam int PROD_W          = 2 * CHAN_W;
    localparam int RCNT_W          = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_WORDS = 2'd1;

    localparam logic [CHAN_W-1:0] BRIGHTNESS_RST  = 8'd255;
    localparam logic [RCNT_W-1:0] RESET_WORDS_RST = 4'd6;

    // Symbols sent for one color bit, MSB first
    localparam logic [SPI_BITS_PER_BIT-1:0] CODE_ZERO = 5'b11000;
    localparam logic [SPI_BITS_PER_BIT-1:0] CODE_ONE  = 5'b11100;

    // One word on its way down the pipe
    typedef struct packed {
        logic              is_reset;
        logic              last;
        logic [CHAN_W-1:0] value;
    } token_t;

endpackage

/* src/lpse_seq.sv */
// ============================================================================
// lpse_seq
// Word sequencer: turns one LED transaction into reset words and channel
// words, one per advancing cycle.
// ============================================================================
module lpse_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [31:0]                 led_color,
    input  logic                        four_channel,
    input  logic                        frame_start,
    input  logic [lpse_pkg::RCNT_W-1:0] reset_words,
    output logic                        tok_valid,
    output lpse_pkg::token_t            tok
);
    import lpse_pkg::*;

    logic              busy_reg, busy_next;
    logic [31:0]       color_reg, color_next;
    logic              four_reg, four_next;
    logic [RCNT_W-1:0] rcnt_reg, rcnt_next;
    logic [1:0]        ch_reg, ch_next;

    logic              is_rst;
    logic              last_ch;
    logic              emit;
    logic              accept;
    logic [CHAN_W-1:0] ch_byte;

    assign is_rst  = (rcnt_reg != '0);
    assign last_ch = four_reg ? (ch_reg == 2'd3) : (ch_reg == 2'd2);
    assign emit    = busy_reg && adv;
    assign in_ready = adv && (!busy_reg || (!is_rst && last_ch));
    assign accept  = in_valid && in_ready;

    // Four-channel order R,G,B,W; three-channel order G,R,B
    always_comb
    begin
        case (ch_reg)
            2'd0:    ch_byte = four_reg ? color_reg[23:16] : color_reg[15:8];
            2'd1:    ch_byte = four_reg ? color_reg[15:8]  : color_reg[23:16];
            2'd2:    ch_byte = color_reg[7:0];
            default: ch_byte = color_reg[31:24];
        endcase
    end

    assign tok_valid    = emit;
    assign tok.is_reset = is_rst;
    assign tok.last     = !is_rst && last_ch;
    assign tok.value    = ch_byte;

    always_comb
    begin
        busy_next  = busy_reg;
        color_next = color_reg;
        four_next  = four_reg;
        rcnt_next  = rcnt_reg;
        ch_next    = ch_reg;
        if (accept)
        begin
            busy_next  = 1'b1;
            color_next = led_color;
            four_next  = four_channel;
            rcnt_next  = frame_start ? reset_words : '0;
            ch_next    = 2'd0;
        end
        else if (emit)
        begin
            if (is_rst)
                rcnt_next = rcnt_reg - RCNT_W'(1);
            else if (last_ch)
                busy_next = 1'b0;
            else
                ch_next = ch_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rcnt_reg <= '0;
            ch_reg   <= '0;
            four_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            rcnt_reg <= rcnt_next;
            ch_reg   <= ch_next;
            four_reg <= four_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
    end

    // An accepted transaction always leaves work behind
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("sequencer idle after accepting a transaction");

    // A reset word is never the end of an item
    a_reset_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_rst) |=> busy_reg)
        else $error("item ended on a reset word");

    // Three-channel items never reach the white slot
    a_rgb_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !four_reg) |-> (ch_reg != 2'd3))
        else $error("three-channel item selected white");

endmodule

/* src/lpse_scale.sv */
// ============================================================================
// lpse_scale
// Brightness scaling, two stages: multiply, then divide by 255.
// ============================================================================
module lpse_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        tok_valid,
    input  lpse_pkg::token_t            tok,
    input  logic [lpse_pkg::CHAN_W-1:0] brightness,
    output logic                        q_valid,
    output lpse_pkg::token_t            q_tok
);
    import lpse_pkg::*;

    logic              a_valid_reg;
    logic              a_is_reset_reg;
    logic              a_last_reg;
    logic [PROD_W-1:0] a_prod_reg;

    logic              b_valid_reg;
    token_t            b_tok_reg;

    logic [PROD_W:0]   quot_sum;

    // floor(p/255) = (p + (p >> 8) + 1) >> 8 for p up to 255*255
    assign quot_sum = {1'b0, a_prod_reg} + (PROD_W+1)'(a_prod_reg >> CHAN_W)
                    + (PROD_W+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= tok_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_is_reset_reg     <= tok.is_reset;
            a_last_reg         <= tok.last;
            a_prod_reg         <= PROD_W'(tok.value) * PROD_W'(brightness);
            b_tok_reg.is_reset <= a_is_reset_reg;
            b_tok_reg.last     <= a_last_reg;
            b_tok_reg.value    <= quot_sum[PROD_W-1:CHAN_W];
        end
    end

    assign q_valid = b_valid_reg;
    assign q_tok   = b_tok_reg;

endmodule

/* src/lpse_enc.sv */
// ============================================================================
// lpse_enc
// Bit expansion and output register: each color bit becomes five SPI bits.
// ============================================================================
module lpse_enc (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        q_valid,
    input  lpse_pkg::token_t            q_tok,
    output logic                        out_valid,
    output logic [lpse_pkg::WORD_W-1:0] spi_word,
    output logic                        last_word
);
    import lpse_pkg::*;

    logic              valid_reg;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              last_reg;

    always_comb
    begin
        word_next = '0;
        if (!q_tok.is_reset)
        begin
            for (int i = 0; i < CHAN_W; i++)
            begin
                word_next[i*SPI_BITS_PER_BIT +: SPI_BITS_PER_BIT] =
                    q_tok.value[i] ? CODE_ONE : CODE_ZERO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
            last_reg <= q_tok.last && !q_tok.is_reset;
        end
    end

    assign out_valid = valid_reg;
    assign spi_word  = word_reg;
    assign last_word = last_reg;

endmodule

/* src/led_pixel_spi_encoder_core.sv */
// ============================================================================
// led_pixel_spi_encoder_core
// Converts LED colors into 40-bit SPI words for a serial addressable LED chain.
// ============================================================================
// One input transaction carries one LED's color (W,R,G,B bytes), a
// four-channel flag and a frame-start flag. It yields one output transaction
// per SPI word: on a frame start, reset_words all-zero words first, then one
// word per channel (R,G,B,W for four-channel LEDs, G,R,B otherwise), the
// final channel word flagged by last_word. Each channel is scaled by
// floor(value * brightness / 255) and sent MSB first, a 0 bit as 11000 and a
// 1 bit as 11100. The sequencer issues one word per clock while the output
// is not stalled, so an LED takes one word per channel, plus reset_words
// words on a frame start; the next LED is accepted in the cycle its last word
// is issued. Words pass through three register stages (multiply, divide by
// 255, bit expansion into the output register). A stall on the output
// freezes the whole pipe. Configuration (index 0 brightness, index 1
// reset_words, other indexes ignored) is always accepted and must only be
// written while the block is idle.
module led_pixel_spi_encoder_core (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lpse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpse_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [31:0]                     led_color,
    input  logic                            four_channel,
    input  logic                            frame_start,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lpse_pkg::WORD_W-1:0]     spi_word,
    output logic                            last_word
);
    import lpse_pkg::*;

    logic [CHAN_W-1:0] brightness_reg;
    logic [RCNT_W-1:0] reset_words_reg;

    // Whole pipe moves when the output register is free or being drained
    logic   adv;
    logic   tok_valid;
    token_t tok;
    logic   q_valid;
    token_t q_tok;

    assign adv       = !out_valid || out_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg  <= BRIGHTNESS_RST;
            reset_words_reg <= RESET_WORDS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BRIGHTNESS:  brightness_reg  <= cfg_data[CHAN_W-1:0];
                CFG_RESET_WORDS: reset_words_reg <= cfg_data[RCNT_W-1:0];
                default:         ;
            endcase
        end
    end

    lpse_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .led_color    (led_color),
        .four_channel (four_channel),
        .frame_start  (frame_start),
        .reset_words  (reset_words_reg),
        .tok_valid    (tok_valid),
        .tok          (tok)
    );

    lpse_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .tok_valid  (tok_valid),
        .tok        (tok),
        .brightness (brightness_reg),
        .q_valid    (q_valid),
        .q_tok      (q_tok)
    );

    lpse_enc u_enc (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .q_valid   (q_valid),
        .q_tok     (q_tok),
        .out_valid (out_valid),
        .spi_word  (spi_word),
        .last_word (last_word)
    );

    // Channel words are never all zero, so a zero word is a reset word
    a_zero_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (spi_word == '0)) |-> !last_word)
        else $error("reset word flagged as last");

    // No new LED enters while the output is blocked
    a_no_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted during output stall");

    // A stalled output word holds steady until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(spi_word) && $stable(last_word)))
        else $error("output word changed while stalled");

endmodule
